FILE: rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// shared widths, command bundle and field layout for the box-to-cell-range block
// ----------------------------------------------------------------------------
`default_nettype none

package obb_pkg;

    localparam int WordW   = 32;              // q16.16 word
    localparam int SizeW   = 31;              // unsigned size / cell size
    localparam int AccW    = 52;              // aabb bound, q16.16 with headroom
    localparam int HalfW   = 64;              // exact q32.32 half-extent sum
    localparam int QuotW   = 31;              // quotient bits before saturation
    localparam int InDataW = 320;
    localparam int OutDataW = 192;
    localparam int MatDepth = 12;

    localparam logic [WordW-1:0] CellReset = 32'd65536;
    localparam logic [WordW-1:0] CellMax   = 32'h7fff_ffff;
    localparam logic [WordW-1:0] CellMin   = 32'h8000_0000;

    localparam logic REQ_ROW = 1'b0;
    localparam logic REQ_BOX = 1'b1;
    localparam logic [1:0] ROW_NONE = 2'd3;

    typedef struct packed {
        logic       row_wr;     // write one matrix row from the input transfer
        logic       capture;    // latch box size and centre
        logic       mat_en;     // walk one matrix entry through the mac
        logic [3:0] mat_idx;
        logic       div_load;   // start a floor division
        logic       div_step;   // one quotient bit
        logic       div_last;   // final quotient bit, store result
        logic [2:0] div_sel;    // 0..2 min x/y/z, 3..5 max x/y/z
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/obb_datapath.sv
// ----------------------------------------------------------------------------
// obb_datapath
// matrix store, shared multiply-accumulate, aabb bounds and bit-serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module obb_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire obb_pkg::cmd_t                   cmd,
    input  wire logic [obb_pkg::InDataW-1:0]     in_data,  // see top level
    input  wire logic [obb_pkg::SizeW-1:0]       cell_len,
    output logic      [obb_pkg::OutDataW-1:0]    out_data
);

    logic signed [obb_pkg::WordW-1:0] mat_reg [obb_pkg::MatDepth];
    logic        [obb_pkg::SizeW-1:0] size_reg [3];
    logic signed [obb_pkg::WordW-1:0] off_reg [3];

    // stage 1: products
    logic signed [47:0]               pc_reg;
    logic        [62:0]               ph_reg;
    logic                             t1_valid_reg;
    logic [1:0]                       t1_k_reg;
    logic [1:0]                       t1_r_reg;
    // stage 2: row accumulators
    logic signed [obb_pkg::AccW-1:0]  accc_reg;
    logic        [obb_pkg::HalfW-1:0] acch_reg;
    logic                             t2_done_reg;
    logic [1:0]                       t2_r_reg;
    // stage 3: bounds
    logic signed [obb_pkg::AccW-1:0]  lo_reg [3];
    logic signed [obb_pkg::AccW-1:0]  hi_reg [3];

    // divider
    logic        [obb_pkg::WordW-1:0] rem_reg;
    logic        [obb_pkg::QuotW-1:0] ulow_reg;
    logic        [obb_pkg::QuotW-1:0] q_reg;
    logic                             neg_reg;
    logic                             sat_reg;
    logic        [obb_pkg::WordW-1:0] res_reg [6];

    logic [1:0]                       rd_k;
    logic signed [obb_pkg::WordW-1:0] rd_m;
    logic [obb_pkg::WordW-1:0]        abs_m;
    logic signed [63:0]               prod_c;
    logic [62:0]                      prod_h;
    logic [1:0]                       ri;
    logic signed [obb_pkg::AccW-1:0]  half;
    logic signed [obb_pkg::AccW-1:0]  div_a;
    logic [obb_pkg::AccW-1:0]         div_u;
    logic [61:0]                      d_shift;
    logic [obb_pkg::SizeW-1:0]        dvs;
    logic [obb_pkg::WordW-1:0]        trial;
    logic [obb_pkg::WordW-1:0]        dvs_w;
    logic                             qbit;
    logic [obb_pkg::QuotW-1:0]        q_next;
    logic [obb_pkg::WordW-1:0]        q_final;

    assign ri    = in_data[1:0];
    assign rd_k  = cmd.mat_idx[1:0];
    assign rd_m  = mat_reg[cmd.mat_idx];
    assign abs_m = rd_m[obb_pkg::WordW-1] ? (~rd_m + 32'd1) : rd_m;
    assign prod_c = (rd_k == 2'd3) ? 64'sd0 : rd_m * off_reg[rd_k];
    assign prod_h = (rd_k == 2'd3) ? 63'd0 : abs_m * size_reg[rd_k];
    assign half  = $signed({5'd0, acch_reg[obb_pkg::HalfW-1:17]});

    // zero cell size acts as one
    assign dvs   = (cell_len == '0) ? 31'd1 : cell_len;
    assign dvs_w = {1'b0, dvs};
    assign div_a = (cmd.div_sel < 3'd3) ? lo_reg[cmd.div_sel[1:0]]
                                        : hi_reg[2'(cmd.div_sel - 3'd3)];
    // floor of a negative value: divide the complement and complement the quotient
    assign div_u   = div_a[obb_pkg::AccW-1] ? ~div_a : div_a;
    assign d_shift = {dvs, 31'd0};
    assign trial   = {rem_reg[30:0], ulow_reg[obb_pkg::QuotW-1]};
    assign qbit    = (trial >= dvs_w);
    assign q_next  = {q_reg[obb_pkg::QuotW-2:0], qbit};
    assign q_final = sat_reg ? (neg_reg ? obb_pkg::CellMin : obb_pkg::CellMax)
                             : (neg_reg ? ~{1'b0, q_next} : {1'b0, q_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < obb_pkg::MatDepth; i++)
            begin
                mat_reg[i] <= '0;
            end
            t1_valid_reg <= 1'b0;
            t2_done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.row_wr && ri != obb_pkg::ROW_NONE)
            begin
                mat_reg[{ri, 2'd0}] <= in_data[33:2];
                mat_reg[{ri, 2'd1}] <= in_data[65:34];
                mat_reg[{ri, 2'd2}] <= in_data[97:66];
                mat_reg[{ri, 2'd3}] <= in_data[129:98];
            end
            t1_valid_reg <= cmd.mat_en;
            t2_done_reg  <= t1_valid_reg && t1_k_reg == 2'd3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            size_reg[0] <= in_data[160:130];
            size_reg[1] <= in_data[191:161];
            size_reg[2] <= in_data[222:192];
            off_reg[0]  <= in_data[254:223];
            off_reg[1]  <= in_data[286:255];
            off_reg[2]  <= in_data[318:287];
        end
        // translation enters at weight one on the last entry of a row
        if (cmd.mat_en)
        begin
            pc_reg   <= (rd_k == 2'd3) ? 48'(rd_m) : prod_c[63:16];
            ph_reg   <= prod_h;
            t1_k_reg <= rd_k;
            t1_r_reg <= cmd.mat_idx[3:2];
        end
        if (t1_valid_reg)
        begin
            if (t1_k_reg == 2'd0)
            begin
                accc_reg <= obb_pkg::AccW'(pc_reg);
                acch_reg <= obb_pkg::HalfW'(ph_reg);
            end
            else
            begin
                accc_reg <= accc_reg + obb_pkg::AccW'(pc_reg);
                acch_reg <= acch_reg + obb_pkg::HalfW'(ph_reg);
            end
            t2_r_reg <= t1_r_reg;
        end
        if (t2_done_reg)
        begin
            lo_reg[t2_r_reg] <= accc_reg - half;
            hi_reg[t2_r_reg] <= accc_reg + half;
        end
        if (cmd.div_load)
        begin
            neg_reg  <= div_a[obb_pkg::AccW-1];
            sat_reg  <= (62'(div_u) >= d_shift);
            rem_reg  <= obb_pkg::WordW'(div_u[obb_pkg::AccW-1:31]);
            ulow_reg <= div_u[30:0];
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= qbit ? (trial - dvs_w) : trial;
            ulow_reg <= {ulow_reg[obb_pkg::QuotW-2:0], 1'b0};
            q_reg    <= q_next;
            if (cmd.div_last)
            begin
                res_reg[cmd.div_sel] <= q_final;
            end
        end
    end

    assign out_data = {res_reg[5], res_reg[4], res_reg[3],
                       res_reg[2], res_reg[1], res_reg[0]};

endmodule

`default_nettype wire

FILE: rtl/obb_ctrl.sv
// ----------------------------------------------------------------------------
// obb_ctrl
// sequencer: matrix walk, pipeline drain, six divisions, result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module obb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_type,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output obb_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAT   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DLOAD = 3'd3;
    localparam logic [2:0] ST_DSTEP = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] sel_reg, sel_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        cmd          = '0;
        cmd.mat_idx  = cnt_reg[3:0];
        cmd.div_sel  = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.row_wr  = in_valid && in_type == obb_pkg::REQ_ROW;
                cmd.capture = in_valid && in_type == obb_pkg::REQ_BOX;
                if (cmd.capture)
                begin
                    state_next = ST_MAT;
                    cnt_next   = '0;
                end
            end
            ST_MAT:
            begin
                cmd.mat_en = 1'b1;
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'(obb_pkg::MatDepth - 1))
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2)
                begin
                    state_next = ST_DLOAD;
                    sel_next   = '0;
                end
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = (cnt_reg == 5'(obb_pkg::QuotW - 1));
                cnt_next     = cnt_reg + 5'd1;
                if (cmd.div_last)
                begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = (sel_reg == 3'd5) ? ST_OUT : ST_DLOAD;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
        else $error("no return to idle after result transfer");
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_load || cmd.div_step || cmd.mat_en) |-> !in_ready && !out_valid)
        else $error("datapath busy while a handshake is open");
    a_last_sel: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.div_last) && $past(sel_reg) == 3'd5)
        else $error("result offered before the last division");
`endif

endmodule

`default_nettype wire

FILE: rtl/obb_to_aabb_cell_range.sv
// ----------------------------------------------------------------------------
// obb_to_aabb_cell_range
// grid cell range covered by an affinely transformed box, q16.16 fixed point
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_*       in         matrix row load or box query
//  m_*       out        min and max grid cell per axis
//  apb       in/out     cell edge length register at byte address 0
//
//  a row load is written when it is accepted; a box query walks the 12
//  matrix entries through the mac, drains the pipeline and runs 6 divisions
//  through the one bit-serial divider before the result transfer.
//  s_tready is low from a box query until its result is taken; a stalled
//  m_tready holds the result. reset clears the matrix and sets the cell
//  size to one unit.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_to_aabb_cell_range (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // row_index, row_c0, row_c1, row_c2, row_translate, size_x, size_y, size_z,
    // centre_x, centre_y, centre_z, one pad bit
    input  wire logic [obb_pkg::InDataW-1:0]   s_tdata,
    // req_type
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // min_cell_x, min_cell_y, min_cell_z, max_cell_x, max_cell_y, max_cell_z
    output logic      [obb_pkg::OutDataW-1:0]  m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    obb_pkg::cmd_t             cmd;
    logic [obb_pkg::SizeW-1:0] cell_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {1'b0, cell_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= obb_pkg::SizeW'(obb_pkg::CellReset);
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            cell_reg <= pwdata[30:0];
        end
    end

    obb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_type   (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    obb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_tdata),
        .cell_len  (cell_reg),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: tb/tb_obb_to_aabb_cell_range.sv
// ----------------------------------------------------------------------------
// tb_obb_to_aabb_cell_range
// stream and apb testbench: matrix row loads and box queries are driven with
// random gaps, each box query's cell range is predicted and compared per field
// ----------------------------------------------------------------------------
`default_nettype none

module tb_obb_to_aabb_cell_range;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LimitCycles = 1500000;
    localparam int  DrainCycles = 300;
    localparam int  RandomItems = 500;
    localparam int  NumDirected = 20;
    localparam logic [2:0] ADDR_CELL_SIZE = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;

    typedef struct packed {
        logic [31:0] max_z;
        logic [31:0] max_y;
        logic [31:0] max_x;
        logic [31:0] min_z;
        logic [31:0] min_y;
        logic [31:0] min_x;
    } cells_t;

    typedef struct {
        logic        kind;
        logic [1:0]  row;
        logic [31:0] c0, c1, c2, tr;
        logic [30:0] sx, sy, sz;
        logic [31:0] ox, oy, oz;
    } item_t;

    typedef struct {
        item_t  it;
        bit     known;
        cells_t want;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [obb_pkg::InDataW-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [obb_pkg::OutDataW-1:0] m_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    obb_to_aabb_cell_range u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic signed [31:0] mat [12];
    logic [30:0] cell_edge;
    cells_t cell_queue [$];
    int errors = 0;
    int n_rows = 0, n_boxes = 0, n_results = 0, n_sat = 0;
    longint cycles = 0;
    bit long_hold = 1'b0;

    task automatic report(input string what);
        errors++;
        $display("mismatch %s at %0t", what, $realtime);
    endtask

    function automatic logic signed [63:0] floor_div(input logic signed [63:0] a,
                                                     input logic signed [63:0] d);
        logic signed [63:0] q;
        if (a >= 0)
            q = a / d;
        else
            q = -((-(a + 1)) / d) - 1;
        return q;
    endfunction

    function automatic logic [31:0] sat_cell(input logic signed [63:0] a,
                                             input logic signed [63:0] d);
        logic signed [63:0] q;
        q = floor_div(a, d);
        if (q > 64'sd2147483647)
            return obb_pkg::CellMax;
        if (q < -64'sd2147483648)
            return obb_pkg::CellMin;
        return q[31:0];
    endfunction

    // applies one accepted item; returns 1 with the predicted cells for a box query
    function automatic bit predict_cells(input item_t it, output cells_t res);
        logic signed [63:0] cs, ctr, half, p, m;
        logic signed [63:0] off [3];
        logic [63:0] sz [3];
        logic [63:0] hsum, am;
        logic [31:0] lo [3], hi [3];
        res = '0;
        if (it.kind == obb_pkg::REQ_ROW)
        begin
            if (it.row != obb_pkg::ROW_NONE)
            begin
                mat[it.row*4+0] = it.c0;
                mat[it.row*4+1] = it.c1;
                mat[it.row*4+2] = it.c2;
                mat[it.row*4+3] = it.tr;
            end
            return 1'b0;
        end
        off[0] = 64'($signed(it.ox));
        off[1] = 64'($signed(it.oy));
        off[2] = 64'($signed(it.oz));
        sz[0] = 64'(it.sx); sz[1] = 64'(it.sy); sz[2] = 64'(it.sz);
        cs = (cell_edge == '0) ? 64'sd1 : $signed({33'd0, cell_edge});
        for (int r = 0; r < 3; r++)
        begin
            ctr = 64'(mat[r*4+3]);
            hsum = '0;
            for (int c = 0; c < 3; c++)
            begin
                m = 64'(mat[r*4+c]);
                p = m * off[c];
                ctr += p >>> 16;
                am = (m < 0) ? -m : m;
                hsum += am * sz[c];
            end
            half = $signed(hsum >> 17);
            lo[r] = sat_cell(ctr - half, cs);
            hi[r] = sat_cell(ctr + half, cs);
        end
        res.min_x = lo[0]; res.min_y = lo[1]; res.min_z = lo[2];
        res.max_x = hi[0]; res.max_y = hi[1]; res.max_z = hi[2];
        return 1'b1;
    endfunction

    function automatic logic [obb_pkg::InDataW-1:0] pack_item(input item_t it);
        return {1'b0, it.oz, it.oy, it.ox, it.sz, it.sy, it.sx,
                it.tr, it.c2, it.c1, it.c0, it.row};
    endfunction

    function automatic item_t row_item(input logic [1:0] r, input logic [31:0] a,
                                       input logic [31:0] b, input logic [31:0] c,
                                       input logic [31:0] t);
        item_t it;
        it = '{default: '0};
        it.kind = obb_pkg::REQ_ROW; it.row = r; it.c0 = a; it.c1 = b; it.c2 = c; it.tr = t;
        return it;
    endfunction

    function automatic item_t box_item(input logic [30:0] sx, input logic [30:0] sy,
                                       input logic [30:0] sz, input logic [31:0] ox,
                                       input logic [31:0] oy, input logic [31:0] oz);
        item_t it;
        it = '{default: '0};
        it.kind = obb_pkg::REQ_BOX; it.sx = sx; it.sy = sy; it.sz = sz;
        it.ox = ox; it.oy = oy; it.oz = oz;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 4) << 16;
            3: return -($urandom_range(0, 4) << 16);
            4: return $urandom() >>> $urandom_range(8, 16);
            default: return $urandom();
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it = '{default: '0};
        it.kind = ($urandom_range(0, 99) < 60) ? obb_pkg::REQ_BOX : obb_pkg::REQ_ROW;
        it.row = ($urandom_range(0, 19) == 0) ? obb_pkg::ROW_NONE
                                              : 2'($urandom_range(0, 2));
        it.c0 = rand_word(); it.c1 = rand_word(); it.c2 = rand_word(); it.tr = rand_word();
        it.sx = 31'(rand_word()); it.sy = 31'(rand_word()); it.sz = 31'(rand_word());
        it.ox = rand_word(); it.oy = rand_word(); it.oz = rand_word();
        return it;
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == ADDR_CELL_SIZE)
            cell_edge = data[30:0];
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic apb_read_check(input logic [31:0] want);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = ADDR_CELL_SIZE;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[30:0] !== want[30:0])
            report($sformatf("cell size readback: got %h want %h", prdata, want));
        @(negedge clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    // one transfer on the input side after an optional random gap
    task automatic send_item(input item_t it, input bit gap);
        cells_t res;
        if (gap)
            repeat ($urandom_range(0, 18)) @(negedge clk);
        s_tdata = pack_item(it);
        s_tuser = it.kind;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (predict_cells(it, res))
        begin
            cell_queue = {cell_queue, res};
            n_boxes++;
        end
        else
            n_rows++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (cell_queue.size() != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // receiver with random stalls and one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready = 1'b0;
                repeat (600) @(negedge clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            m_tready = (gap == 0);
            if (gap != 0)
            begin
                repeat (gap) @(negedge clk);
                m_tready = 1'b1;
            end
            @(posedge clk);
            while (!(m_tvalid && m_tready)) @(posedge clk);
        end
    end

    // result check
    always @(posedge clk)
    begin
        cells_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            n_results++;
            if (cell_queue.size() == 0)
            begin
                report($sformatf("unexpected result transfer %h", m_tdata));
            end
            else
            begin
                want = cell_queue.pop_front();
                if (got.min_x == obb_pkg::CellMin || got.max_x == obb_pkg::CellMax)
                    n_sat++;
                if (got.min_x !== want.min_x)
                    report($sformatf("min_cell_x: got %h want %h", got.min_x, want.min_x));
                if (got.min_y !== want.min_y)
                    report($sformatf("min_cell_y: got %h want %h", got.min_y, want.min_y));
                if (got.min_z !== want.min_z)
                    report($sformatf("min_cell_z: got %h want %h", got.min_z, want.min_z));
                if (got.max_x !== want.max_x)
                    report($sformatf("max_cell_x: got %h want %h", got.max_x, want.max_x));
                if (got.max_y !== want.max_y)
                    report($sformatf("max_cell_y: got %h want %h", got.max_y, want.max_y));
                if (got.max_z !== want.max_z)
                    report($sformatf("max_cell_z: got %h want %h", got.max_z, want.max_z));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LimitCycles)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        vec_t dir [NumDirected];
        cells_t res, zero_cells;
        logic [31:0] sizes [5];
        zero_cells = '0;
        for (int i = 0; i < 12; i++) mat[i] = '0;
        cell_edge = 31'(obb_pkg::CellReset);

        // reset state: zero matrix maps every box to cell zero
        dir[0]  = '{box_item(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                             32'h8000_0000, 32'h7fff_ffff, 32'h0), 1'b1, zero_cells};
        dir[1]  = '{row_item(2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0003_0000), 1'b0, '0};
        dir[2]  = '{row_item(2'd1, 32'h0, 32'h0001_0000, 32'h0, 32'hfffe_0000), 1'b0, '0};
        dir[3]  = '{row_item(2'd2, 32'h0, 32'h0, 32'h0001_0000, 32'h0), 1'b0, '0};
        dir[4]  = '{box_item(31'h0002_0000, 31'h0002_0000, 31'h0002_0000,
                             32'h0, 32'h0, 32'h0), 1'b0, '0};
        // row index three must leave the matrix untouched
        dir[5]  = '{row_item(obb_pkg::ROW_NONE, 32'hffff_ffff, 32'hffff_ffff,
                             32'hffff_ffff, 32'hffff_ffff), 1'b0, '0};
        dir[6]  = '{box_item(31'h0001_8000, 31'h0, 31'h7fff_ffff,
                             32'hffff_8000, 32'h0000_8000, 32'h8000_0000), 1'b0, '0};
        // extreme matrix drives the cells into saturation
        dir[7]  = '{row_item(2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000), 1'b0, '0};
        dir[8]  = '{row_item(2'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h7fff_ffff), 1'b0, '0};
        dir[9]  = '{row_item(2'd2, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1), 1'b0, '0};
        dir[10] = '{box_item(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0, '0};
        dir[11] = '{box_item(31'h0, 31'h0, 31'h0,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, '0};
        dir[12] = '{box_item(31'h1, 31'h5555_5555, 31'h2aaa_aaaa,
                             32'h5555_5555, 32'haaaa_aaaa, 32'h1), 1'b0, '0};
        dir[13] = '{row_item(2'd0, 32'hffff_ffff, 32'h1, 32'h5555_5555,
                             32'haaaa_aaaa), 1'b0, '0};
        dir[14] = '{row_item(2'd1, 32'h0000_8000, 32'hffff_8000, 32'h0, 32'h7fff_ffff),
                    1'b0, '0};
        dir[15] = '{row_item(2'd2, 32'hffff_0000, 32'h0, 32'h0002_0000, 32'h8000_0000),
                    1'b0, '0};
        dir[16] = '{box_item(31'h0003_0000, 31'h0000_0001, 31'h0001_0000,
                             32'hfffc_0000, 32'h0000_ffff, 32'hffff_ffff), 1'b0, '0};
        dir[17] = '{box_item(31'h7fff_0000, 31'h0, 31'h0000_ffff,
                             32'h0, 32'h8000_0001, 32'h7fff_0000), 1'b0, '0};
        dir[18] = '{row_item(2'd0, 32'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0};
        dir[19] = '{box_item(31'h1234_5678, 31'h0765_4321, 31'h0,
                             32'h0001_0000, 32'hffff_0000, 32'h0), 1'b0, '0};

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        apb_read_check(obb_pkg::CellReset);

        for (int i = 0; i < NumDirected; i++)
        begin
            send_item(dir[i].it, 1'b1);
            if (dir[i].known && dir[i].it.kind == obb_pkg::REQ_BOX)
            begin
                res = cell_queue[$];
                if (res !== dir[i].want)
                    report($sformatf("directed row %0d: predictor disagrees with table", i));
            end
        end
        wait_idle();

        // cell sizes: smallest, zero (treated as one), largest, unit, random
        sizes[0] = 32'd1;
        sizes[1] = 32'd0;
        sizes[2] = 32'h7fff_ffff;
        sizes[3] = obb_pkg::CellReset;
        sizes[4] = $urandom_range(1, 32'h0010_0000);
        for (int ph = 0; ph < 5; ph++)
        begin
            apb_write(ADDR_CELL_SIZE, sizes[ph]);
            apb_write(ADDR_UNUSED, $urandom());
            apb_read_check(sizes[ph]);
            for (int k = 0; k < RandomItems / 5; k++)
            begin
                if (ph == 2 && k == 10)
                    long_hold = 1'b1;
                send_item(rand_item(), $urandom_range(0, 4) != 0 && !(ph == 3 && k < 30));
            end
            wait_idle();
        end

        $display("%0d row loads and %0d box queries sent, %0d results checked", n_rows,
                 n_boxes, n_results);
        $display("five cell sizes incl. zero and maximum, %0d saturated x results", n_sat);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
